// ===== rtl/icw_pkg.sv =====
// icw_pkg: shared types, codes and constants for the iq calibrate/window block
// no dependencies; imported by icw_ctrl, icw_datapath, the top level and the checker

package icw_pkg;

	// fixed field widths
	localparam int SAMPLE_BITS = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int TIDX_W      = 10;
	localparam int RBIN_W      = 10;
	localparam int DLINE_W     = 8;
	localparam int SPL_W       = 11;
	localparam int LPB_W       = 9;

	// parameter defaults
	localparam int DEF_MAX_RANGE_BINS = 1024;
	localparam int DEF_MAX_LINES      = 256;

	// request function codes
	localparam logic [1:0] FUNC_SAMPLE    = 2'd0;
	localparam logic [1:0] FUNC_DC_WR     = 2'd1;
	localparam logic [1:0] FUNC_RANGE_WR  = 2'd2;
	localparam logic [1:0] FUNC_DOPPLER_WR = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DC_CONST_ONLY    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DC_OFFSET_CONST  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_II           = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_IQ           = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_QI           = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL_QQ           = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_LINE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_LINES_PER_BLOCK  = 3'd7;

	// configuration reset values
	localparam logic signed [15:0] CAL_UNITY = 16'sd16384;
	localparam logic [SPL_W-1:0]   SPL_RESET = 11'd1024;
	localparam logic [LPB_W-1:0]   LPB_RESET = 9'd256;

	// commands from controller to datapath
	typedef struct packed {
		logic take_sample;
		logic take_table;
		logic step_diff;
		logic step_mul1;
		logic step_mul2;
		logic step_wide;
		logic load_out;
		logic out_pop;
	} icw_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic out_valid;
	} icw_status_t;

endpackage

// ===== rtl/icw_ram.sv =====
// icw_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module icw_ram #(
	parameter int DATA_W = 16,
	parameter int DEPTH  = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/icw_ctrl.sv =====
// icw_ctrl: sequencing state machine for the iq calibrate/window datapath
// depends on icw_pkg (command and status structs, function codes)

module icw_ctrl import icw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic        out_ready,
	input  icw_status_t status,
	output icw_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIFF = 3'd1;
	localparam logic [2:0] ST_MUL1 = 3'd2;
	localparam logic [2:0] ST_MUL2 = 3'd3;
	localparam logic [2:0] ST_WIDE = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       take;
	logic       out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid & in_ready;
	assign out_free = ~status.out_valid | out_ready;

	always_comb begin
		cmd.take_sample = take & (func == FUNC_SAMPLE);
		cmd.take_table  = take & (func != FUNC_SAMPLE);
		cmd.step_diff   = (state_q == ST_DIFF);
		cmd.step_mul1   = (state_q == ST_MUL1);
		cmd.step_mul2   = (state_q == ST_MUL2);
		cmd.step_wide   = (state_q == ST_WIDE);
		cmd.load_out    = (state_q == ST_FIN) & out_free;
		cmd.out_pop     = status.out_valid & out_ready;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take && (func == FUNC_SAMPLE)) begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: state_d = ST_MUL1;
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_WIDE;
			ST_WIDE: state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/icw_datapath.sv =====
// icw_datapath: config registers, counters, tables and the calibrate/window arithmetic
// depends on icw_pkg and icw_ram

module icw_datapath import icw_pkg::*; #(
	parameter int MAX_RANGE_BINS = DEF_MAX_RANGE_BINS,
	parameter int MAX_LINES      = DEF_MAX_LINES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  icw_cmd_t                     cmd,
	output icw_status_t                  status,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic [1:0]                   func,
	input  logic signed [15:0]           sample_i,
	input  logic signed [15:0]           sample_q,
	input  logic [TIDX_W-1:0]            table_index,
	input  logic signed [15:0]           table_offset_i,
	input  logic signed [15:0]           table_offset_q,
	input  logic [15:0]                  table_weight,
	output logic signed [15:0]           out_i,
	output logic signed [15:0]           out_q,
	output logic [RBIN_W-1:0]            range_bin,
	output logic [DLINE_W-1:0]           doppler_line,
	output logic                         last_of_block,
	output logic                         saturated
);

	localparam int RB_AW = $clog2(MAX_RANGE_BINS);
	localparam int LN_AW = $clog2(MAX_LINES);
	localparam int RW    = 22;
	localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);
	localparam logic signed [51:0]   ROUND_HALF = 52'sd1 <<< 29;

	// configuration registers
	logic                   dc_const_only_q;
	logic signed [15:0]     dc_offset_const_q;
	logic signed [15:0]     cal_ii_q, cal_iq_q, cal_qi_q, cal_qq_q;
	logic [SPL_W-1:0]       spl_q;
	logic [LPB_W-1:0]       lpb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_const_only_q   <= 1'b1;
			dc_offset_const_q <= '0;
			cal_ii_q          <= CAL_UNITY;
			cal_iq_q          <= '0;
			cal_qi_q          <= '0;
			cal_qq_q          <= CAL_UNITY;
			spl_q             <= SPL_RESET;
			lpb_q             <= LPB_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DC_CONST_ONLY:    dc_const_only_q   <= cfg_data[0];
				CFG_DC_OFFSET_CONST:  dc_offset_const_q <= cfg_data;
				CFG_CAL_II:           cal_ii_q          <= cfg_data;
				CFG_CAL_IQ:           cal_iq_q          <= cfg_data;
				CFG_CAL_QI:           cal_qi_q          <= cfg_data;
				CFG_CAL_QQ:           cal_qq_q          <= cfg_data;
				CFG_SAMPLES_PER_LINE: spl_q             <= cfg_data[SPL_W-1:0];
				CFG_LINES_PER_BLOCK:  lpb_q             <= cfg_data[LPB_W-1:0];
				default: ;
			endcase
		end
	end

	// range / line counters
	logic [RB_AW-1:0] range_cnt_q;
	logic [LN_AW-1:0] line_cnt_q;
	logic [31:0]      spl_c, lpb_c, rb_next, dl_next;
	logic             end_line, end_block;

	always_comb begin
		if (spl_q == '0) begin
			spl_c = 32'd1;
		end else if (32'(spl_q) > 32'(MAX_RANGE_BINS)) begin
			spl_c = 32'(MAX_RANGE_BINS);
		end else begin
			spl_c = 32'(spl_q);
		end
		if (lpb_q == '0) begin
			lpb_c = 32'd1;
		end else if (32'(lpb_q) > 32'(MAX_LINES)) begin
			lpb_c = 32'(MAX_LINES);
		end else begin
			lpb_c = 32'(lpb_q);
		end
		rb_next   = 32'(range_cnt_q) + 32'd1;
		dl_next   = 32'(line_cnt_q) + 32'd1;
		end_line  = (rb_next >= spl_c);
		end_block = end_line & (dl_next >= lpb_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_cnt_q <= '0;
			line_cnt_q  <= '0;
		end else if (cmd.take_sample) begin
			if (end_line) begin
				range_cnt_q <= '0;
				line_cnt_q  <= end_block ? '0 : LN_AW'(dl_next);
			end else begin
				range_cnt_q <= RB_AW'(rb_next);
			end
		end
	end

	// tables
	logic        dc_we, rw_we, dw_we;
	logic [31:0] dc_rd;
	logic [15:0] rw_rd, dw_rd;

	assign dc_we = cmd.take_table & (func == FUNC_DC_WR)
		& (32'(table_index) < 32'(MAX_RANGE_BINS));
	assign rw_we = cmd.take_table & (func == FUNC_RANGE_WR)
		& (32'(table_index) < 32'(MAX_RANGE_BINS));
	assign dw_we = cmd.take_table & (func == FUNC_DOPPLER_WR)
		& (32'(table_index) < 32'(MAX_LINES));

	icw_ram #(.DATA_W(32), .DEPTH(MAX_RANGE_BINS)) u_dc_table (
		.clk   (clk),
		.we    (dc_we),
		.waddr (RB_AW'(table_index)),
		.wdata ({table_offset_i, table_offset_q}),
		.re    (cmd.take_sample),
		.raddr (range_cnt_q),
		.rdata (dc_rd)
	);

	icw_ram #(.DATA_W(16), .DEPTH(MAX_RANGE_BINS)) u_range_win (
		.clk   (clk),
		.we    (rw_we),
		.waddr (RB_AW'(table_index)),
		.wdata (table_weight),
		.re    (cmd.take_sample),
		.raddr (range_cnt_q),
		.rdata (rw_rd)
	);

	icw_ram #(.DATA_W(16), .DEPTH(MAX_LINES)) u_doppler_win (
		.clk   (clk),
		.we    (dw_we),
		.waddr (LN_AW'(table_index)),
		.wdata (table_weight),
		.re    (cmd.take_sample),
		.raddr (line_cnt_q),
		.rdata (dw_rd)
	);

	// stage 1: captured sample and position
	logic signed [15:0]  si_s1, sq_s1;
	logic [RBIN_W-1:0]   rb_s1;
	logic [DLINE_W-1:0]  dl_s1;
	logic                last_s1;

	always_ff @(posedge clk) begin
		if (cmd.take_sample) begin
			si_s1   <= sample_i;
			sq_s1   <= sample_q;
			rb_s1   <= RBIN_W'(range_cnt_q);
			dl_s1   <= DLINE_W'(line_cnt_q);
			last_s1 <= end_block;
		end
	end

	// stage 2: offset removal, raw weight product
	logic signed [15:0] oi, oq;
	logic signed [16:0] di_s2, dq_s2;
	logic [31:0]        wraw_s2;

	assign oi = dc_const_only_q ? dc_offset_const_q : $signed(dc_rd[31:16]);
	assign oq = dc_const_only_q ? dc_offset_const_q : $signed(dc_rd[15:0]);

	always_ff @(posedge clk) begin
		if (cmd.step_diff) begin
			di_s2   <= 17'(si_s1) - 17'(oi);
			dq_s2   <= 17'(sq_s1) - 17'(oq);
			wraw_s2 <= 32'(rw_rd) * 32'(dw_rd);
		end
	end

	// stage 3: direct matrix terms, rounded window weight
	logic signed [32:0] pi_s3, pq_s3;
	logic [15:0]        w_s3;
	logic [32:0]        wsum;

	assign wsum = {1'b0, wraw_s2} + 33'd32768;

	always_ff @(posedge clk) begin
		if (cmd.step_mul1) begin
			pi_s3 <= 33'(cal_ii_q) * 33'(di_s2);
			pq_s3 <= 33'(cal_qq_q) * 33'(dq_s2);
			w_s3  <= wsum[31:16];
		end
	end

	// stage 4: cross terms accumulated
	logic signed [33:0] acci_s4, accq_s4;
	logic [15:0]        w_s4;

	always_ff @(posedge clk) begin
		if (cmd.step_mul2) begin
			acci_s4 <= 34'(pi_s3) + 34'(cal_iq_q) * 34'(dq_s2);
			accq_s4 <= 34'(pq_s3) + 34'(cal_qi_q) * 34'(di_s2);
			w_s4    <= w_s3;
		end
	end

	// stage 5: acc * w split into high and low partial products
	logic signed [16:0] w_sgn;
	logic signed [33:0] phi_s5, phq_s5;
	logic [32:0]        pli_s5, plq_s5;

	assign w_sgn = $signed({1'b0, w_s4});

	always_ff @(posedge clk) begin
		if (cmd.step_wide) begin
			phi_s5 <= 34'($signed(acci_s4[33:17])) * 34'(w_sgn);
			phq_s5 <= 34'($signed(accq_s4[33:17])) * 34'(w_sgn);
			pli_s5 <= 33'(acci_s4[16:0]) * 33'(w_s4);
			plq_s5 <= 33'(accq_s4[16:0]) * 33'(w_s4);
		end
	end

	// final: recombine, round half up, saturate
	logic signed [51:0]   toti, totq;
	logic signed [RW-1:0] ri, rq;
	logic signed [15:0]   oi_sat, oq_sat;
	logic                 sat_i, sat_q;

	always_comb begin
		toti = ({{18{phi_s5[33]}}, phi_s5} <<< 17) + $signed({19'b0, pli_s5}) + ROUND_HALF;
		totq = ({{18{phq_s5[33]}}, phq_s5} <<< 17) + $signed({19'b0, plq_s5}) + ROUND_HALF;
		ri   = toti[51:30];
		rq   = totq[51:30];
		sat_i = (ri > SAT_HI) | (ri < SAT_LO);
		sat_q = (rq > SAT_HI) | (rq < SAT_LO);
		if (ri > SAT_HI) begin
			oi_sat = 16'(SAT_HI);
		end else if (ri < SAT_LO) begin
			oi_sat = 16'(SAT_LO);
		end else begin
			oi_sat = 16'(ri);
		end
		if (rq > SAT_HI) begin
			oq_sat = 16'(SAT_HI);
		end else if (rq < SAT_LO) begin
			oq_sat = 16'(SAT_LO);
		end else begin
			oq_sat = 16'(rq);
		end
	end

	// output register
	logic                out_valid_q;
	logic signed [15:0]  out_i_q, out_q_q;
	logic [RBIN_W-1:0]   rb_q;
	logic [DLINE_W-1:0]  dl_q;
	logic                last_q, sat_q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (cmd.out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_i_q <= oi_sat;
			out_q_q <= oq_sat;
			rb_q    <= rb_s1;
			dl_q    <= dl_s1;
			last_q  <= last_s1;
			sat_q_q <= sat_i | sat_q;
		end
	end

	assign status.out_valid = out_valid_q;
	assign out_i            = out_i_q;
	assign out_q            = out_q_q;
	assign range_bin        = rb_q;
	assign doppler_line     = dl_q;
	assign last_of_block    = last_q;
	assign saturated        = sat_q_q;

endmodule

// ===== rtl/iq_calibrate_window.sv =====
// iq_calibrate_window: top level, joins the sequencing controller and the datapath
// depends on icw_pkg, icw_ctrl, icw_datapath (and icw_ram below it)
//
// usage
//   input channel (in_valid/in_ready) carries one request per handshake; func
//   selects a sample (result produced) or a table write (dc offset pair, range
//   weight or doppler weight; no result). table writes are taken one per cycle
//   while no sample is in progress. at the accepting edge the three tables are
//   read at the current range bin and doppler line, then offset removal, direct
//   matrix terms, cross terms, split wide window multiply, and round/saturate
//   follow, one step per cycle through the controller's sequence, the last step
//   waiting while the output register is still held. the result then shows on
//   out_valid; in_ready returns in that same cycle, so a new sample waits for it.
//   output channel (out_valid/out_ready) is fed from an output register; a
//   stalled receiver holds the result there and the block still finishes the
//   next sample up to the final step, where it waits until the register frees.
//   config port (cfg_we/cfg_index/cfg_data) writes the indexed register and
//   is meant for idle periods only.
//   reset (arst_n low) restores config defaults, clears both counters and the
//   output valid; table contents are undefined until written, no clearing pass

module iq_calibrate_window import icw_pkg::*; #(
	parameter int MAX_RANGE_BINS = DEF_MAX_RANGE_BINS,
	parameter int MAX_LINES      = DEF_MAX_LINES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input request channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            func,
	input  logic signed [15:0]    sample_i,
	input  logic signed [15:0]    sample_q,
	input  logic [TIDX_W-1:0]     table_index,
	input  logic signed [15:0]    table_offset_i,
	input  logic signed [15:0]    table_offset_q,
	input  logic [15:0]           table_weight,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [15:0]    out_i,
	output logic signed [15:0]    out_q,
	output logic [RBIN_W-1:0]     range_bin,
	output logic [DLINE_W-1:0]    doppler_line,
	output logic                  last_of_block,
	output logic                  saturated
);

	icw_cmd_t    cmd;
	icw_status_t status;

	// sequencing: accepts requests, steps the arithmetic, owns the stall at the end
	icw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// registers, counters, tables, multipliers and the output register
	icw_datapath #(
		.MAX_RANGE_BINS (MAX_RANGE_BINS),
		.MAX_LINES      (MAX_LINES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.func           (func),
		.sample_i       (sample_i),
		.sample_q       (sample_q),
		.table_index    (table_index),
		.table_offset_i (table_offset_i),
		.table_offset_q (table_offset_q),
		.table_weight   (table_weight),
		.out_i          (out_i),
		.out_q          (out_q),
		.range_bin      (range_bin),
		.doppler_line   (doppler_line),
		.last_of_block  (last_of_block),
		.saturated      (saturated)
	);

	// result valid comes straight from the output register
	assign out_valid = status.out_valid;

endmodule

// ===== rtl/icw_checker.sv =====
// icw_checker: port-level assertions for iq_calibrate_window, attached by bind
// depends on icw_pkg and the iq_calibrate_window port list

module icw_checker import icw_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [1:0]            func,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic signed [15:0]    out_i,
	input logic signed [15:0]    out_q,
	input logic                  saturated
);

	// a held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_i) && $stable(out_q))
	else $error("result changed while stalled");

	// a sample request leaves in_ready low in the cycle after it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == FUNC_SAMPLE |=> !in_ready)
	else $error("request taken while a sample is in progress");

	// a table write never produces a result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func != FUNC_SAMPLE && !out_valid |=> !out_valid)
	else $error("result appeared after a table write");

	// the saturation flag comes with a clipped value on at least one output
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> out_i == 16'sh7fff || out_i == -16'sh8000
			|| out_q == 16'sh7fff || out_q == -16'sh8000)
	else $error("saturated flag without a clipped output");

endmodule

bind iq_calibrate_window icw_checker u_icw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.func      (func),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_i     (out_i),
	.out_q     (out_q),
	.saturated (saturated)
);
